[rtl/cmst_pkg.sv]
// Shared constants, request codes and cell control type for the counting multiset table.
package cmst_pkg;

    localparam int DEPTH_DEFAULT       = 64;
    localparam int KEY_WIDTH_DEFAULT   = 32;
    localparam int COUNT_WIDTH_DEFAULT = 16;
    localparam int CAP_RESET           = 64;
    localparam int KIND_W              = 3;

    localparam logic [KIND_W-1:0] KIND_INSERT    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ERASE_ONE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ERASE_ALL = 3'd2;
    localparam logic [KIND_W-1:0] KIND_COUNT     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_GET       = 3'd4;

    // Broadcast to every cell of the row.
    typedef struct packed {
        logic lookup;   // capture match flags
        logic by_pos;   // match on position rather than key
        logic inc;      // matching entry count + 1
        logic dec;      // matching entry count - 1
        logic drop;     // matching entry and everything after it shift down
        logic append;   // first empty cell takes the key with count one
    } t_cell_ctrl;

endpackage

[rtl/cmst_cell.sv]
// One table cell: holds a key and its count, compares, and shifts from its upper neighbour.
module cmst_cell #(
    parameter int KEY_WIDTH   = cmst_pkg::KEY_WIDTH_DEFAULT,
    parameter int COUNT_WIDTH = cmst_pkg::COUNT_WIDTH_DEFAULT,
    parameter int POS_W       = 6
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  cmst_pkg::t_cell_ctrl   i_ctrl,
    input  logic [POS_W-1:0]       i_index,
    input  logic [KEY_WIDTH-1:0]   i_key,
    input  logic [POS_W-1:0]       i_pos,
    input  logic                   i_prev_valid,
    input  logic                   i_seen,
    input  logic [KEY_WIDTH-1:0]   i_next_key,
    input  logic [COUNT_WIDTH-1:0] i_next_count,
    output logic [KEY_WIDTH-1:0]   o_key,
    output logic [COUNT_WIDTH-1:0] o_count,
    output logic                   o_valid,
    output logic                   o_seen,
    output logic                   o_hit,
    output logic [KEY_WIDTH-1:0]   o_hit_key,
    output logic [COUNT_WIDTH-1:0] o_hit_count
);

    logic [KEY_WIDTH-1:0]   r_key;
    logic [COUNT_WIDTH-1:0] r_count;
    logic                   r_hit;
    logic                   r_after;
    logic                   w_valid;
    logic                   w_match;
    logic                   w_first_empty;

    // a cell is in use exactly while its count is nonzero
    assign w_valid       = (r_count != '0);
    assign w_match       = i_ctrl.by_pos ? (w_valid && (i_index == i_pos))
                                         : (w_valid && (r_key == i_key));
    assign w_first_empty = !w_valid && i_prev_valid;

    assign o_key       = r_key;
    assign o_count     = r_count;
    assign o_valid     = w_valid;
    assign o_seen      = i_seen | w_match;
    assign o_hit       = r_hit;
    assign o_hit_key   = r_hit ? r_key : '0;
    assign o_hit_count = r_hit ? r_count : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_hit   <= 1'b0;
            r_after <= 1'b0;
        end else begin
            if (i_ctrl.lookup) begin
                r_hit   <= w_match;
                r_after <= i_seen | w_match;
            end
            if (i_ctrl.drop && r_after) begin
                r_key   <= i_next_key;
                r_count <= i_next_count;
            end else if (i_ctrl.inc && r_hit) begin
                r_count <= r_count + 1'b1;
            end else if (i_ctrl.dec && r_hit) begin
                r_count <= r_count - 1'b1;
            end else if (i_ctrl.append && w_first_empty) begin
                r_key   <= i_key;
                r_count <= COUNT_WIDTH'(1);
            end
        end
    end

endmodule

[rtl/counting_multiset_table_core.sv]
// Top level of the counting multiset table: request sequencing, totals and the cell row.
// Each request is handled in two steps: the cycle in which it is accepted compares the key
// (or position) against every cell of the row at once, and the following cycle updates the
// cells, shifting the entries above a removed one down by one place in that single step.
// The result appears on the o_ ports for exactly one cycle with o_done high, from the same
// clock edge at which o_busy falls; a new request may be accepted in that same cycle, but
// none while o_busy is high. The receiver cannot stall: results must be taken
// when o_done is high. The capacity is written with i_cfg_we, which the user must assert
// only while no request is in flight, since the block has no check; it is clamped to DEPTH.
module counting_multiset_table_core #(
    parameter int DEPTH       = cmst_pkg::DEPTH_DEFAULT,
    parameter int KEY_WIDTH   = cmst_pkg::KEY_WIDTH_DEFAULT,
    parameter int COUNT_WIDTH = cmst_pkg::COUNT_WIDTH_DEFAULT,
    localparam int POS_W      = $clog2(DEPTH),
    localparam int CAP_W      = $clog2(DEPTH + 1),
    localparam int TOTAL_W    =
        $clog2(64'(DEPTH) * ((64'd1 << COUNT_WIDTH) - 64'd1) + 64'd1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CAP_W-1:0]            i_cfg_data,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic [cmst_pkg::KIND_W-1:0] i_kind,
    input  logic [KEY_WIDTH-1:0]        i_key,
    input  logic [POS_W-1:0]            i_position,
    output logic                        o_done,
    output logic                        o_ok,
    output logic [COUNT_WIDTH-1:0]      o_count_out,
    output logic [KEY_WIDTH-1:0]        o_key_out,
    output logic [CAP_W-1:0]            o_distinct_entries,
    output logic [TOTAL_W-1:0]          o_total_items
);

    typedef enum logic {S_IDLE, S_APPLY} t_state;

    localparam logic [CAP_W-1:0] CAP_RST =
        CAP_W'((DEPTH < cmst_pkg::CAP_RESET) ? DEPTH : cmst_pkg::CAP_RESET);
    localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(DEPTH);

    t_state                        r_state;
    logic [CAP_W-1:0]              r_capacity;
    logic [cmst_pkg::KIND_W-1:0]   r_kind;
    logic [KEY_WIDTH-1:0]          r_key;
    logic [CAP_W-1:0]              r_used;
    logic [TOTAL_W-1:0]            r_total;

    logic [CAP_W-1:0]              n_used;
    logic [TOTAL_W-1:0]            n_total;
    logic                          n_ok;
    logic [COUNT_WIDTH-1:0]        n_count;
    logic [KEY_WIDTH-1:0]          n_key_out;

    cmst_pkg::t_cell_ctrl          w_ctrl;
    logic                          w_accept;
    logic [KEY_WIDTH-1:0]          w_cell_key;
    logic [CAP_W-1:0]              w_cap;
    logic                          w_hit_any;
    logic [COUNT_WIDTH-1:0]        w_hit_count;
    logic [KEY_WIDTH-1:0]          w_hit_key;
    logic [TOTAL_W-1:0]            w_hit_count_ext;

    logic [KEY_WIDTH-1:0]          w_key   [DEPTH];
    logic [COUNT_WIDTH-1:0]        w_count [DEPTH];
    logic [DEPTH-1:0]              w_valid;
    logic [DEPTH-1:0]              w_seen;
    logic [DEPTH-1:0]              w_hit;
    logic [KEY_WIDTH-1:0]          w_hkey  [DEPTH];
    logic [COUNT_WIDTH-1:0]        w_hcnt  [DEPTH];

    assign o_busy     = (r_state == S_APPLY);
    assign w_accept   = i_start && (r_state == S_IDLE);
    // lookup uses the request on the ports; an append later uses the held key
    assign w_cell_key = (r_state == S_IDLE) ? i_key : r_key;
    assign w_cap      = (r_capacity > CAP_MAX) ? CAP_MAX : r_capacity;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            cmst_cell #(
                .KEY_WIDTH   (KEY_WIDTH),
                .COUNT_WIDTH (COUNT_WIDTH),
                .POS_W       (POS_W)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (w_ctrl),
                .i_index      (POS_W'(g)),
                .i_key        (w_cell_key),
                .i_pos        (i_position),
                .i_prev_valid ((g == 0) ? 1'b1 : w_valid[(g == 0) ? 0 : g - 1]),
                .i_seen       ((g == 0) ? 1'b0 : w_seen[(g == 0) ? 0 : g - 1]),
                .i_next_key   ((g == DEPTH - 1) ? '0 : w_key[(g == DEPTH - 1) ? g : g + 1]),
                .i_next_count ((g == DEPTH - 1) ? '0 : w_count[(g == DEPTH - 1) ? g : g + 1]),
                .o_key        (w_key[g]),
                .o_count      (w_count[g]),
                .o_valid      (w_valid[g]),
                .o_seen       (w_seen[g]),
                .o_hit        (w_hit[g]),
                .o_hit_key    (w_hkey[g]),
                .o_hit_count  (w_hcnt[g])
            );
        end
    endgenerate

    // at most one cell holds a hit, so the readout is a plain OR over the row
    always_comb begin
        w_hit_key   = '0;
        w_hit_count = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_hit_key   = w_hit_key | w_hkey[i];
            w_hit_count = w_hit_count | w_hcnt[i];
        end
        w_hit_any       = |w_hit;
        w_hit_count_ext = TOTAL_W'(w_hit_count);
    end

    always_comb begin
        w_ctrl        = '0;
        w_ctrl.lookup = w_accept;
        w_ctrl.by_pos = (i_kind == cmst_pkg::KIND_GET);
        n_used        = r_used;
        n_total       = r_total;
        n_ok          = 1'b0;
        n_count       = '0;
        n_key_out     = '0;
        if (r_state == S_APPLY) begin
            case (r_kind)
                cmst_pkg::KIND_INSERT: begin
                    if (w_hit_any) begin
                        if (w_hit_count != '1) begin
                            w_ctrl.inc = 1'b1;
                            n_total    = r_total + 1'b1;
                            n_ok       = 1'b1;
                        end
                    end else if (r_used < w_cap) begin
                        w_ctrl.append = 1'b1;
                        n_used        = r_used + 1'b1;
                        n_total       = r_total + 1'b1;
                        n_ok          = 1'b1;
                    end
                end
                cmst_pkg::KIND_ERASE_ONE: begin
                    if (w_hit_any) begin
                        n_ok    = 1'b1;
                        n_count = COUNT_WIDTH'(1);
                        if (w_hit_count > COUNT_WIDTH'(1)) begin
                            w_ctrl.dec = 1'b1;
                        end else begin
                            w_ctrl.drop = 1'b1;
                            n_used      = r_used - 1'b1;
                        end
                        if (r_total != '0) begin
                            n_total = r_total - 1'b1;
                        end
                    end
                end
                cmst_pkg::KIND_ERASE_ALL: begin
                    if (w_hit_any) begin
                        n_ok        = 1'b1;
                        n_count     = w_hit_count;
                        w_ctrl.drop = 1'b1;
                        n_used      = r_used - 1'b1;
                        n_total     = (r_total >= w_hit_count_ext) ? r_total - w_hit_count_ext
                                                                   : '0;
                    end
                end
                cmst_pkg::KIND_COUNT: begin
                    if (w_hit_any) begin
                        n_ok    = 1'b1;
                        n_count = w_hit_count;
                    end
                end
                cmst_pkg::KIND_GET: begin
                    if (w_hit_any) begin
                        n_ok      = 1'b1;
                        n_count   = w_hit_count;
                        n_key_out = w_hit_key;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state            <= S_IDLE;
            r_capacity         <= CAP_RST;
            r_used             <= '0;
            r_total            <= '0;
            o_done             <= 1'b0;
            o_ok               <= 1'b0;
            o_count_out        <= '0;
            o_key_out          <= '0;
            o_distinct_entries <= '0;
            o_total_items      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_data;
            end
            o_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_kind  <= i_kind;
                        r_key   <= i_key;
                        r_state <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    r_used             <= n_used;
                    r_total            <= n_total;
                    o_done             <= 1'b1;
                    o_ok               <= n_ok;
                    o_count_out        <= n_count;
                    o_key_out          <= n_key_out;
                    o_distinct_entries <= n_used;
                    o_total_items      <= n_total;
                    r_state            <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
